[hw/rtl/cce_pkg.sv]
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, character codes and the byte expansion function for the
// control character expander.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned MaxRun  = 4;
  localparam int unsigned CountW  = 3;  // holds 0..MaxRun
  localparam int unsigned IdxW    = 2;  // indexes 0..MaxRun-1

  localparam logic [ByteW-1:0] ChBs    = 8'h08;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChDel   = 8'h7F;
  localparam logic [ByteW-1:0] ChCaret = 8'h5E;
  localparam logic [ByteW-1:0] ChAt    = 8'h40;
  localparam logic [ByteW-1:0] ChQuery = 8'h3F;
  localparam logic [ByteW-1:0] ChM     = 8'h4D;
  localparam logic [ByteW-1:0] ChDash  = 8'h2D;
  localparam logic [ByteW-1:0] ChH     = 8'h48;
  localparam logic [ByteW-1:0] LowMask = 8'h7F;

  // register indexes on the configuration channel
  typedef enum logic [0:0] {
    REG_BACKSPACE_MODE = 1'b0,
    REG_CONTROL_MODE   = 1'b1
  } cce_reg_t;

  // modes; code 3 is folded in the expander (drop for backspace, show for controls)
  localparam logic [ModeW-1:0] ModeDrop = 2'd0;
  localparam logic [ModeW-1:0] ModePass = 2'd1;
  localparam logic [ModeW-1:0] ModeShow = 2'd2;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    byte_t [MaxRun-1:0] seq;
    logic [CountW-1:0]  count;
  } run_t;

  function automatic logic is_ctrl(input byte_t c);
    return (c < 8'h20) || (c == ChDel);
  endfunction

  function automatic byte_t caret_letter(input byte_t c);
    return (c == ChDel) ? ChQuery : byte_t'(c + ChAt);
  endfunction

  function automatic run_t expand(input byte_t c, input logic [ModeW-1:0] bs_mode,
                                  input logic [ModeW-1:0] ctl_mode);
    run_t  r;
    byte_t low;
    logic  show;
    r.seq   = '0;
    r.count = '0;
    low     = c & LowMask;
    show    = ctl_mode[1];  // codes 2 and 3 both mean visible notation
    if (c == ChBs) begin
      if (bs_mode == ModePass) begin
        r.seq[0] = c;
        r.count  = 3'd1;
      end else if (bs_mode == ModeShow) begin
        r.seq[0] = ChCaret;
        r.seq[1] = ChH;
        r.count  = 3'd2;
      end
    end else if (c[ByteW-1]) begin
      if (ctl_mode == ModePass) begin
        r.seq[0] = c;
        r.count  = 3'd1;
      end else if (show) begin
        r.seq[0] = ChM;
        r.seq[1] = ChDash;
        if (is_ctrl(low)) begin
          r.seq[2] = ChCaret;
          r.seq[3] = caret_letter(low);
          r.count  = 3'd4;
        end else begin
          r.seq[2] = low;
          r.count  = 3'd3;
        end
      end
    end else if (is_ctrl(c) && (c != ChTab) && (c != ChNl)) begin
      if (ctl_mode == ModePass) begin
        r.seq[0] = c;
        r.count  = 3'd1;
      end else if (show) begin
        r.seq[0] = ChCaret;
        r.seq[1] = caret_letter(c);
        r.count  = 3'd2;
      end
    end else begin
      r.seq[0] = c;
      r.count  = 3'd1;
    end
    return r;
  endfunction

endpackage

[hw/rtl/control_char_expander_core.sv]
// ----------------------------------------------------------------------------
// control_char_expander_core
// Turns each input byte into zero to four bytes (raw, or caret and
// M- notation), one output word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Datapath: an accepted input word is held in the input register; its output words pass through the output register.
// Throughput: one input word per cycle when each expands to one byte and the receiver is ready; a word
//   expanding to N bytes holds the input register until its last output word is loaded (one output
//   word per cycle while the receiver is ready). Dropped bytes retire with no output.
// Reset: synchronous rst empties both registers; both modes return to pass.
module control_char_expander_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] in_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic                       m_tlast,   // last_of_run
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [cce_pkg::ModeW-1:0]  cfg_data
);
  import cce_pkg::*;

  logic [ModeW-1:0] bs_mode;
  logic [ModeW-1:0] ctl_mode;

  logic             in_valid;
  byte_t            in_byte;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  idx_next;

  logic             out_valid;
  byte_t            out_byte;
  logic             out_last;

  run_t             run;
  logic             out_free;
  logic             out_load;
  logic             run_last;
  logic             in_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bs_mode  <= ModePass;
      ctl_mode <= ModePass;
    end else if (cfg_valid) begin
      unique case (cce_reg_t'(cfg_index))
        REG_BACKSPACE_MODE: bs_mode  <= cfg_data;
        REG_CONTROL_MODE:   ctl_mode <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign run      = expand(in_byte, bs_mode, ctl_mode);
  assign out_free = !out_valid || m_tready;
  assign run_last = ({1'b0, idx} == (run.count - 3'd1));
  assign out_load = in_valid && (run.count != '0) && out_free;
  // a dropped byte retires without touching the output register
  assign in_done  = in_valid && ((run.count == '0) || (out_load && run_last));
  assign s_tready = !in_valid || in_done;
  assign idx_next = in_done ? '0 : (out_load ? idx + 2'd1 : idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idx      <= '0;
    end else begin
      idx <= idx_next;
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (in_done) begin
        in_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= run.seq[idx];
      out_last <= run_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

[hw/rtl/cce_checker.sv]
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks on the control character expander output stream.
// ----------------------------------------------------------------------------
module cce_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import cce_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // the rest of a run follows without a bubble
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside an expanded run");

  // a caret inside a run is always the next to last byte
  a_caret_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata == ChCaret) && !m_tlast |=> m_tvalid && m_tlast)
    else $error("caret not followed by closing letter");

  a_meta_dash: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata == ChM) && !m_tlast
      |=> (m_tdata == ChDash) && !m_tlast)
    else $error("M not followed by dash inside run");

endmodule

bind control_char_expander_core cce_checker u_cce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for control_char_expander_core. Bytes go in over the
// slave stream in random bursts while the master side stalls on its own
// pattern. Each accepted byte is expanded into caret / M- notation under the
// current mode settings. Every output word, data and tlast, is checked in
// order against those expected bytes. The modes are rewritten between
// phases once the block has drained.
// ----------------------------------------------------------------------------
module tb;
  import cce_pkg::*;

  localparam int unsigned LIMIT      = 300000;
  localparam int unsigned DRAIN_WAIT = 4;     // covers the input and output registers
  localparam int unsigned PHASE_RUNS = 30;    // bytes with output per phase

  typedef struct {
    byte_t data;
    logic  last;
  } out_word_t;

  // expected output words of the expander, oldest first
  class notation_checker;
    out_word_t      expected_words[$];
    logic [ModeW-1:0] bs_mode  = ModePass;
    logic [ModeW-1:0] ctl_mode = ModePass;
    int             fails    = 0;

    function void set_mode(cce_reg_t idx, logic [ModeW-1:0] val);
      if (idx == REG_BACKSPACE_MODE) bs_mode = val;
      else ctl_mode = val;
    endfunction

    function bit is_control(byte_t c);
      return (c < 8'h20) || (c == ChDel);
    endfunction

    function byte_t caret_of(byte_t c);
      byte_t letter;
      letter = c + ChAt;
      return (c == ChDel) ? ChQuery : letter;
    endfunction

    // bytes that one input byte turns into under the current modes
    function void expand_byte(byte_t c, output byte_t run[$]);
      logic [ModeW-1:0] cm;
      byte_t            low;
      run = {};
      cm  = (ctl_mode == 2'd3) ? ModeShow : ctl_mode;
      low = c & LowMask;
      if (c == ChBs) begin
        if (bs_mode == ModePass) begin
          run.push_back(c);
        end else if (bs_mode == ModeShow) begin
          run.push_back(ChCaret);
          run.push_back(ChH);
        end
      end else if (c[7]) begin
        if (cm == ModePass) begin
          run.push_back(c);
        end else if (cm == ModeShow) begin
          run.push_back(ChM);
          run.push_back(ChDash);
          if (is_control(low)) begin
            run.push_back(ChCaret);
            run.push_back(caret_of(low));
          end else begin
            run.push_back(low);
          end
        end
      end else if (is_control(c) && c != ChTab && c != ChNl) begin
        if (cm == ModePass) begin
          run.push_back(c);
        end else if (cm == ModeShow) begin
          run.push_back(ChCaret);
          run.push_back(caret_of(c));
        end
      end else begin
        run.push_back(c);
      end
    endfunction

    function void note_byte(byte_t c);
      byte_t     run[$];
      out_word_t w;
      expand_byte(c, run);
      foreach (run[i]) begin
        w.data = run[i];
        w.last = (i == run.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(byte_t d, logic last);
      out_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word data=%02h last=%0b", $time, d, last);
        fails++;
        return;
      end
      w = expected_words.pop_front();
      if (d !== w.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, w.data, d);
        fails++;
      end
      if (last !== w.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, w.last, last);
        fails++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             m_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [ModeW-1:0] cfg_data = '0;

  notation_checker  board = new();
  int unsigned      cycles = 0;
  int               burst_left = 0;
  logic             hold_req = 1'b0;
  logic             hold_taken = 1'b0;
  int               hold_cnt = 0;
  int               pat_cnt = 0;
  int               stall_style = 0;

  control_char_expander_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("control_char_expander_core: mismatch");
      $finish;
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_byte(s_tdata);
      if (m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
    end
  end

  // receiver: stall style drawn at random from four patterns, plus one long hold on request
  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    if (pat_cnt % 50 == 0) stall_style <= $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_cnt   <= 120;
      hold_taken <= 1'b1;
    end else begin
      case (stall_style)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (pat_cnt % 8 != 0);
      endcase
    end
  end

  // called right after a rising edge
  task automatic send_byte(byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    // dropped bytes may still be in flight
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cce_reg_t idx, logic [ModeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_mode(idx, val);
  endtask

  function automatic byte_t random_byte();
    byte_t specials[6] = '{ChBs, ChTab, ChNl, ChDel, 8'h89, 8'hFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return byte_t'($urandom_range(0, 255));
      4, 5:       return byte_t'($urandom_range(0, 8'h1F));
      6:          return specials[$urandom_range(0, 5)];
      7, 8:       return byte_t'($urandom_range(8'h80, 8'h9F));
      default:    return byte_t'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  initial begin
    byte_t            dir_reset[5] = '{ChBs, ChDel, 8'h80, 8'hFF, 8'h41};
    byte_t            dir_show[16] = '{8'h00, ChBs, ChTab, ChNl, 8'h1F, 8'h20, 8'h41,
                                       8'h7E, ChDel, 8'h80, 8'h88, 8'h89, 8'h8A,
                                       8'h9F, 8'hC1, 8'hFF};
    logic [ModeW-1:0] bs_set[8]  = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    logic [ModeW-1:0] ctl_set[8] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3};
    byte_t            run[$];
    byte_t            b;
    int               emitted;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modes: everything passes raw
    foreach (dir_reset[i]) send_byte(dir_reset[i]);
    wait_drained();

    write_reg(REG_BACKSPACE_MODE, ModeShow);
    write_reg(REG_CONTROL_MODE, ModeShow);
    foreach (dir_show[i]) send_byte(dir_show[i]);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_BACKSPACE_MODE, bs_set[p]);
      write_reg(REG_CONTROL_MODE, ctl_set[p]);
      if (p == 1) hold_req <= 1'b1;  // long receiver hold, input must back up
      emitted = 0;
      while (emitted < PHASE_RUNS) begin
        if (p == 5 && emitted == PHASE_RUNS / 2) begin
          wait_drained();
          emitted++;
        end
        b = random_byte();
        board.expand_byte(b, run);
        if (run.size() > 0) emitted++;
        send_byte(b);
      end
      wait_drained();
    end

    if (board.fails == 0 && board.pending() == 0) begin
      $display("control_char_expander_core: match");
    end else begin
      $display("control_char_expander_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cce_pkg.sv
hw/rtl/control_char_expander_core.sv
hw/rtl/cce_checker.sv
test/tb.sv
